>>> rtl/core/csl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types and constants for the chip-select lease table.
// ----------------------------------------------------------------------------
package csl_pkg;

	localparam int MaxLeases = 4;
	localparam int PinW      = 8;

	typedef enum logic [1:0] {
		CMD_ACQUIRE     = 2'd0,
		CMD_RELEASE     = 2'd1,
		CMD_QUERY       = 2'd2,
		CMD_RELEASE_ALL = 2'd3
	} cmd_t;

	typedef logic [MaxLeases-1:0] slot_vec_t;

	// one request word presented to the table for a single cycle
	typedef struct packed {
		logic            valid;
		cmd_t            cmd;
		logic [PinW-1:0] pin;
	} req_t;

endpackage

>>> rtl/core/chip_select_lease_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip_select_lease_table
// Table of chip-select pin leases: acquire, release, query, release all.
// ----------------------------------------------------------------------------
// One request word is taken per cycle while in_stall is low, and each gives one
// result word. A request is held in the input register, where it is matched
// against all slots at once and the table is updated as it moves on; the result
// is then held in the output register until the receiver takes it. The next
// request sees the table as left by the one before it. All leases are free
// after reset.
module chip_select_lease_table (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               cmd,
	input  logic [csl_pkg::PinW-1:0] pin,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     ok
);

	logic                     valid_s1;
	csl_pkg::cmd_t            cmd_s1;
	logic [csl_pkg::PinW-1:0] pin_s1;
	logic                     valid_s2;
	logic                     ok_s2;
	logic                     adv;
	logic                     tbl_ok;
	csl_pkg::req_t            req;

	// s1 word moves to the output register when that register is free or draining
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	assign req.valid = adv;
	assign req.cmd   = cmd_s1;
	assign req.pin   = pin_s1;

	csl_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ok     (tbl_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1 <= csl_pkg::cmd_t'(cmd);
			pin_s1 <= pin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s2 <= tbl_ok;
		end
	end

	assign out_valid = valid_s2;
	assign ok        = ok_s2;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced word did not reach output register");

	a_release_all_nak: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd_s1 == csl_pkg::CMD_RELEASE_ALL) |=> !ok_s2)
		else $error("release all reported ok");

endmodule

>>> rtl/core/csl_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_table
// Lease storage with parallel pin match, lowest-free-slot pick and update.
// ----------------------------------------------------------------------------
module csl_table (
	input  logic          clk,
	input  logic          arst_n,
	input  csl_pkg::req_t req,
	output logic          ok
);

	logic [csl_pkg::PinW-1:0] lease_pin_q [csl_pkg::MaxLeases];
	csl_pkg::slot_vec_t       lease_active_q;
	csl_pkg::slot_vec_t       active_d;
	csl_pkg::slot_vec_t       hit;
	csl_pkg::slot_vec_t       held_oh;
	csl_pkg::slot_vec_t       free_oh;
	csl_pkg::slot_vec_t       pin_wr;

	always_comb begin
		for (int i = 0; i < csl_pkg::MaxLeases; i++) begin
			hit[i] = lease_active_q[i] && (lease_pin_q[i] == req.pin);
		end
	end

	// isolate lowest set bit of hit and lowest clear bit of the active marks
	assign held_oh = hit & (~hit + csl_pkg::slot_vec_t'(1));
	assign free_oh = ~lease_active_q & (lease_active_q + csl_pkg::slot_vec_t'(1));

	always_comb begin
		ok       = 1'b0;
		active_d = lease_active_q;
		pin_wr   = '0;
		unique case (req.cmd)
			csl_pkg::CMD_ACQUIRE: begin
				ok = ~|hit && |free_oh;
				if (ok) begin
					active_d = lease_active_q | free_oh;
					pin_wr   = free_oh;
				end
			end
			csl_pkg::CMD_RELEASE: begin
				ok       = |hit;
				active_d = lease_active_q & ~held_oh;
			end
			csl_pkg::CMD_QUERY: begin
				ok = |hit;
			end
			csl_pkg::CMD_RELEASE_ALL: begin
				ok       = 1'b0;
				active_d = '0;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lease_active_q <= '0;
		end else if (req.valid) begin
			lease_active_q <= active_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < csl_pkg::MaxLeases; i++) begin
			if (req.valid && pin_wr[i]) begin
				lease_pin_q[i] <= req.pin;
			end
		end
	end

endmodule

>>> bench/tb_chip_select_lease_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chip_select_lease_table
// Self-checking bench for the chip-select lease table.
// ----------------------------------------------------------------------------
// Directed requests cover empty, duplicate and full tables, misses and
// release all. A random stream follows that draws pins from a small pool,
// so leases collide and fill up. A bit-level lease tracker predicts each
// ok bit. Sender bursts and receiver stalls vary throughout the run.
module tb_chip_select_lease_table;

	typedef struct {
		csl_pkg::cmd_t            op;
		logic [csl_pkg::PinW-1:0] pin;
	} lease_req_t;

	typedef struct {
		csl_pkg::cmd_t            op;
		logic [csl_pkg::PinW-1:0] pin;
		logic                     ok;
	} lease_result_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_stall;
	csl_pkg::cmd_t            cmd       = csl_pkg::CMD_ACQUIRE;
	logic [csl_pkg::PinW-1:0] pin       = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     ok;

	lease_req_t               pending[$];
	lease_result_t            lease_expect[$];
	logic [csl_pkg::PinW-1:0] held_pin[csl_pkg::MaxLeases];
	bit                       slot_live[csl_pkg::MaxLeases];
	int                       words_in    = 0;
	int                       words_total = 0;
	int                       fault_count = 0;
	logic                     word_taken  = 1'b0;
	int                       burst_left  = 0;
	int                       gap_left    = 0;
	int                       stall_mode  = 0;
	int                       stall_left  = 0;
	int                       stall_phase = 0;

	chip_select_lease_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.pin      (pin),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok       (ok)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// lease tracker: updates the table for one request and returns its ok bit
	function automatic logic lease_update(csl_pkg::cmd_t op, logic [csl_pkg::PinW-1:0] p);
		int   hit;
		int   free_slot;
		logic granted;
		hit       = -1;
		free_slot = -1;
		granted   = 1'b0;
		for (int i = csl_pkg::MaxLeases - 1; i >= 0; i--) begin
			if (slot_live[i] && held_pin[i] == p)
				hit = i;
			if (!slot_live[i])
				free_slot = i;
		end
		case (op)
			csl_pkg::CMD_ACQUIRE: begin
				if (hit < 0 && free_slot >= 0) begin
					held_pin[free_slot]  = p;
					slot_live[free_slot] = 1'b1;
					granted              = 1'b1;
				end
			end
			csl_pkg::CMD_RELEASE: begin
				if (hit >= 0) begin
					slot_live[hit] = 1'b0;
					granted        = 1'b1;
				end
			end
			csl_pkg::CMD_QUERY: begin
				granted = (hit >= 0);
			end
			default: begin
				for (int i = 0; i < csl_pkg::MaxLeases; i++)
					slot_live[i] = 1'b0;
			end
		endcase
		return granted;
	endfunction

	function automatic void queue_word(csl_pkg::cmd_t op, logic [csl_pkg::PinW-1:0] p);
		lease_req_t w;
		w.op  = op;
		w.pin = p;
		pending.push_back(w);
		words_total++;
	endfunction

	// sender: bursts of words separated by random gaps
	always @(negedge clk) begin
		lease_req_t w;
		logic       go;
		if (arst_n && (!in_valid || word_taken)) begin
			go = 1'b0;
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
			if (burst_left != 0 && pending.size() != 0) begin
				w = pending.pop_front();
				cmd <= w.op;
				pin <= w.pin;
				go = 1'b1;
				burst_left--;
			end else if (burst_left == 0 && gap_left != 0) begin
				gap_left--;
			end
			in_valid <= go;
		end
	end

	// receiver: stall behavior switches between a few modes
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(10, 80);
		end else begin
			stall_left--;
		end
		stall_phase++;
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(0, 99) < 30);
			2:       out_stall <= (stall_phase % 3 == 0);
			default: out_stall <= ($urandom_range(0, 99) < 85);
		endcase
	end

	// monitor: check results, then record newly accepted requests
	always @(posedge clk) begin
		lease_result_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (lease_expect.size() == 0) begin
					if (fault_count < 10)
						$display("%0t: result word with no request pending, ok=%0b",
							$realtime, ok);
					fault_count++;
				end else begin
					e = lease_expect.pop_front();
					if (ok !== e.ok) begin
						if (fault_count < 10)
							$display("%0t: %s pin=0x%02h expected ok=%0b got %0b",
								$realtime, e.op.name(), e.pin, e.ok, ok);
						fault_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				e.op  = cmd;
				e.pin = pin;
				e.ok  = lease_update(cmd, pin);
				lease_expect.push_back(e);
				words_in <= words_in + 1;
			end
			word_taken <= in_valid && !in_stall;
		end
	end

	initial begin
		logic [csl_pkg::PinW-1:0] pin_pool[6];
		int                       r;
		csl_pkg::cmd_t            op;
		logic [csl_pkg::PinW-1:0] p;
		for (int i = 0; i < csl_pkg::MaxLeases; i++) begin
			slot_live[i] = 1'b0;
			held_pin[i]  = '0;
		end

		// directed: empty table, duplicates, full table, misses, release all
		queue_word(csl_pkg::CMD_QUERY,       8'h00);
		queue_word(csl_pkg::CMD_RELEASE,     8'h00);
		queue_word(csl_pkg::CMD_ACQUIRE,     8'h00);
		queue_word(csl_pkg::CMD_ACQUIRE,     8'hFF);
		queue_word(csl_pkg::CMD_ACQUIRE,     8'h00);
		queue_word(csl_pkg::CMD_ACQUIRE,     8'hAA);
		queue_word(csl_pkg::CMD_ACQUIRE,     8'h55);
		queue_word(csl_pkg::CMD_ACQUIRE,     8'h01);
		queue_word(csl_pkg::CMD_QUERY,       8'hFF);
		queue_word(csl_pkg::CMD_QUERY,       8'h01);
		queue_word(csl_pkg::CMD_RELEASE,     8'hFF);
		queue_word(csl_pkg::CMD_ACQUIRE,     8'h0F);
		queue_word(csl_pkg::CMD_QUERY,       8'hFF);
		queue_word(csl_pkg::CMD_RELEASE,     8'h0F);
		queue_word(csl_pkg::CMD_RELEASE,     8'h0F);
		queue_word(csl_pkg::CMD_RELEASE_ALL, 8'hA5);
		queue_word(csl_pkg::CMD_QUERY,       8'h00);
		queue_word(csl_pkg::CMD_RELEASE,     8'hAA);
		queue_word(csl_pkg::CMD_ACQUIRE,     8'hFF);
		queue_word(csl_pkg::CMD_ACQUIRE,     8'hFF);
		queue_word(csl_pkg::CMD_QUERY,       8'hFF);
		queue_word(csl_pkg::CMD_RELEASE_ALL, 8'h00);
		queue_word(csl_pkg::CMD_RELEASE_ALL, 8'hFF);
		queue_word(csl_pkg::CMD_ACQUIRE,     8'h80);

		// random: pins mostly from a small pool so leases collide and fill up
		for (int n = 0; n < 830; n++) begin
			if (n % 40 == 0) begin
				for (int k = 0; k < 6; k++)
					pin_pool[k] = csl_pkg::PinW'($urandom_range(0, 255));
				if ($urandom_range(0, 2) == 0) begin
					pin_pool[0] = 8'h00;
					pin_pool[1] = 8'hFF;
				end
			end
			r = $urandom_range(0, 99);
			if (r < 40)
				op = csl_pkg::CMD_ACQUIRE;
			else if (r < 68)
				op = csl_pkg::CMD_RELEASE;
			else if (r < 92)
				op = csl_pkg::CMD_QUERY;
			else
				op = csl_pkg::CMD_RELEASE_ALL;
			if ($urandom_range(0, 99) < 15)
				p = csl_pkg::PinW'($urandom_range(0, 255));
			else
				p = pin_pool[$urandom_range(0, 5)];
			queue_word(op, p);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_in != words_total)
			@(posedge clk);
		while (lease_expect.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fault_count == 0 && lease_expect.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
